// ----- rtl/core/slp_pkg.sv -----
// ----------------------------------------------------------------------------
// slp_pkg
// Shared types and codes of the stage latency profiler.
// ----------------------------------------------------------------------------
package slp_pkg;

  localparam logic [1:0] OP_BEGIN  = 2'd0;
  localparam logic [1:0] OP_END    = 2'd1;
  localparam logic [1:0] OP_COMMIT = 2'd2;

  localparam logic CFG_BIN_WIDTH    = 1'b0;
  localparam logic CFG_REPORT_EVERY = 1'b1;

  localparam logic [15:0] BIN_WIDTH_RST    = 16'd100;
  localparam logic [15:0] REPORT_EVERY_RST = 16'd50;
  localparam logic [31:0] PCT_DIVISOR      = 32'd100;
  // x / 100 == (x * PCT_RECIP) >> PCT_SHIFT for every 32-bit x
  localparam logic [31:0] PCT_RECIP        = 32'h51EB_851F;
  localparam int          PCT_SHIFT        = 37;
  localparam logic [15:0] BIN_SAT          = 16'hFFFF;

  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_LINE   = 1'b1;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  stage;
    logic [31:0] time_us;
  } slp_in_t;

  typedef struct packed {
    logic        kind;
    logic [3:0]  stage_index;
    logic [31:0] frame_total;
    logic [31:0] min_us;
    logic [31:0] mean_us;
    logic [31:0] max_us;
    logic [21:0] p99_us;
    logic        last;
  } slp_out_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FOLD,
    ST_BIN_WAIT,
    ST_HIST_RD,
    ST_HIST_WR,
    ST_FRAME,
    ST_RPT_WAIT,
    ST_HDR,
    ST_LSEL,
    ST_MEAN_WAIT,
    ST_PCT_WAIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_P99_MUL,
    ST_LPUSH
  } slp_state_t;

endpackage

// ----- rtl/core/slp_front.sv -----
// ----------------------------------------------------------------------------
// slp_front
// Takes requests, keeps begin stamps and frame totals, queues commit snapshots.
// ----------------------------------------------------------------------------
module slp_front #(
  parameter int STAGES = 10
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_push,
  input  slp_pkg::slp_in_t         in_data,
  output logic                     in_full,
  input  logic                     clearing,
  output logic                     cmt_valid,
  output logic [STAGES-1:0][31:0]  cmt_accum,
  input  logic                     cmt_pop
);
  import slp_pkg::*;

  localparam int SW = (STAGES > 1) ? $clog2(STAGES) : 1;

  logic [31:0]             stamp_r [STAGES];
  logic [STAGES-1:0][31:0] accum_r;
  logic [STAGES-1:0][31:0] q_r [2];
  logic                    wr_ptr_r, rd_ptr_r;
  logic [1:0]              q_cnt_r;
  logic                    accept, in_range, q_push;
  logic [SW-1:0]           sidx;

  assign in_full   = (q_cnt_r == 2'd2) || clearing;
  assign accept    = in_push && !in_full;
  assign in_range  = ({28'd0, in_data.stage} < 32'(STAGES));
  assign sidx      = SW'(in_data.stage);
  assign q_push    = accept && (in_data.op == OP_COMMIT);
  assign cmt_valid = (q_cnt_r != 2'd0);
  assign cmt_accum = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        stamp_r[i] <= '0;
      end
      accum_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      q_cnt_r  <= 2'd0;
    end else begin
      if (accept) begin
        case (in_data.op)
          OP_BEGIN: begin
            if (in_range) stamp_r[sidx] <= in_data.time_us;
          end
          OP_END: begin
            if (in_range) accum_r[sidx] <= accum_r[sidx] + (in_data.time_us - stamp_r[sidx]);
          end
          OP_COMMIT: begin
            // snapshot totals for the back end, start a fresh frame
            q_r[wr_ptr_r] <= accum_r;
            accum_r       <= '0;
          end
          default: ;
        endcase
      end
      if (q_push) wr_ptr_r <= ~wr_ptr_r;
      if (cmt_pop) rd_ptr_r <= ~rd_ptr_r;
      case ({q_push, cmt_pop})
        2'b10:   q_cnt_r <= q_cnt_r + 2'd1;
        2'b01:   q_cnt_r <= q_cnt_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/slp_div.sv -----
// ----------------------------------------------------------------------------
// slp_div
// Restoring divider, 64 by 32 bits, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module slp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [31:0] rem
);
  logic [63:0] dvd_r;
  logic [31:0] rem_r, dvs_r;
  logic [5:0]  cnt_r;
  logic        run_r, done_r;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_r, dvd_r[63]};
  assign ge    = (trial >= {1'b0, dvs_r});
  assign diff  = trial - {1'b0, dvs_r};
  assign done  = done_r;
  assign quot  = dvd_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dvd_r <= dividend;
        dvs_r <= divisor;
        rem_r <= '0;
        cnt_r <= '0;
        run_r <= 1'b1;
      end else if (run_r) begin
        dvd_r <= {dvd_r[62:0], ge};
        rem_r <= ge ? diff[31:0] : trial[31:0];
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/slp_back.sv -----
// ----------------------------------------------------------------------------
// slp_back
// Folds frame totals into statistics and histogram, builds reports.
// ----------------------------------------------------------------------------
module slp_back #(
  parameter int STAGES    = 10,
  parameter int HIST_BINS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [15:0]              bin_width,
  input  logic [15:0]              report_every,
  input  logic                     cmt_valid,
  input  logic [STAGES-1:0][31:0]  cmt_accum,
  output logic                     cmt_pop,
  output logic                     clearing,
  output logic                     res_push,
  output slp_pkg::slp_out_t        res_data,
  input  logic                     res_full
);
  import slp_pkg::*;

  localparam int SW   = (STAGES > 1) ? $clog2(STAGES) : 1;
  localparam int CW   = $clog2(STAGES + 1);
  localparam int BW   = $clog2(HIST_BINS);
  localparam int BCW  = $clog2(HIST_BINS + 1);
  localparam int HN   = STAGES * HIST_BINS;
  localparam int HA   = $clog2(HN);

  slp_state_t state_r, state_nxt;

  logic [31:0]  min_r [STAGES];
  logic [31:0]  max_r [STAGES];
  logic [63:0]  sum_r [STAGES];
  logic [31:0]  cnt_r [STAGES];
  logic [31:0]  frames_r;
  logic [CW-1:0] s_r;
  logic [BW-1:0] b_r;
  logic [BCW-1:0] mult_r;
  logic [HA-1:0] haddr_r;
  logic [15:0]  hdata_r;
  logic [31:0]  acc_r, target_r, mean_r;
  logic [63:0]  pct_prod_r;
  logic [21:0]  p99_r;
  logic [15:0]  hist_mem [HN];

  logic          div_start, div_done;
  logic [63:0]   div_dvd, div_quot;
  logic [31:0]   div_dvs, div_rem;
  logic [15:0]   eff_w;
  logic [SW-1:0] sidx;
  logic [31:0]   t_cur, acc_sum;
  logic [STAGES-1:0] nz;
  logic          above_nz, last_stage, hit, last_bin;
  logic [HA-1:0] row_base;
  logic [BW-1:0] bin_clamp;
  logic [BCW+15:0] prod;

  slp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign eff_w      = (bin_width == 16'd0) ? 16'd1 : bin_width;
  assign sidx       = s_r[SW-1:0];
  assign t_cur      = cmt_accum[sidx];
  assign last_stage = (s_r == CW'(STAGES - 1));
  assign row_base   = HA'(32'(sidx) * 32'(HIST_BINS));
  assign bin_clamp  = (div_quot >= 64'(HIST_BINS)) ? BW'(HIST_BINS - 1) : div_quot[BW-1:0];
  assign acc_sum    = acc_r + {16'd0, hdata_r};
  assign hit        = (acc_sum >= target_r);
  assign last_bin   = (b_r == BW'(HIST_BINS - 1));
  assign prod       = mult_r * eff_w;
  assign clearing   = (state_r == ST_CLEAR);

  always_comb begin
    above_nz = 1'b0;
    for (int i = 0; i < STAGES; i++) begin
      nz[i] = (cnt_r[i] != 32'd0);
      if (nz[i] && (32'(i) > 32'(s_r))) above_nz = 1'b1;
    end
  end

  always_comb begin
    res_data = '0;
    if (state_r == ST_HDR) begin
      res_data.kind        = KIND_HEADER;
      res_data.frame_total = frames_r;
      res_data.last        = (nz == '0);
    end else begin
      res_data.kind        = KIND_LINE;
      res_data.stage_index = 4'(s_r);
      res_data.min_us      = min_r[sidx];
      res_data.mean_us     = mean_r;
      res_data.max_us      = max_r[sidx];
      res_data.p99_us      = p99_r;
      res_data.last        = !above_nz;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    div_dvd   = {32'd0, t_cur};
    div_dvs   = {16'd0, eff_w};
    cmt_pop   = 1'b0;
    res_push  = 1'b0;
    case (state_r)
      ST_CLEAR:    if (haddr_r == HA'(HN - 1)) state_nxt = ST_IDLE;
      ST_IDLE:     if (cmt_valid) state_nxt = ST_FOLD;
      ST_FOLD: begin
        div_start = 1'b1;
        state_nxt = ST_BIN_WAIT;
      end
      ST_BIN_WAIT: if (div_done) state_nxt = ST_HIST_RD;
      ST_HIST_RD:  state_nxt = ST_HIST_WR;
      ST_HIST_WR:  state_nxt = last_stage ? ST_FRAME : ST_FOLD;
      ST_FRAME: begin
        cmt_pop = 1'b1;
        div_dvd = {32'd0, frames_r + 32'd1};
        div_dvs = {16'd0, report_every};
        if (report_every == 16'd0) begin
          state_nxt = ST_IDLE;
        end else begin
          div_start = 1'b1;
          state_nxt = ST_RPT_WAIT;
        end
      end
      ST_RPT_WAIT: if (div_done) state_nxt = (div_rem == 32'd0) ? ST_HDR : ST_IDLE;
      ST_HDR: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_LSEL;
        end
      end
      ST_LSEL: begin
        div_dvd = sum_r[sidx];
        div_dvs = cnt_r[sidx];
        if (s_r == CW'(STAGES)) begin
          state_nxt = ST_IDLE;
        end else if (nz[sidx]) begin
          div_start = 1'b1;
          state_nxt = ST_MEAN_WAIT;
        end
      end
      ST_MEAN_WAIT: if (div_done) state_nxt = ST_PCT_WAIT;
      ST_PCT_WAIT: state_nxt = ST_SCAN_RD;
      ST_SCAN_RD:  state_nxt = ST_SCAN_CHK;
      ST_SCAN_CHK: state_nxt = (hit || last_bin) ? ST_P99_MUL : ST_SCAN_RD;
      ST_P99_MUL:  state_nxt = ST_LPUSH;
      ST_LPUSH: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = ST_LSEL;
        end
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // histogram store: single port, registered read
  always_ff @(posedge clk) begin
    hdata_r <= hist_mem[haddr_r];
    if (state_r == ST_CLEAR) begin
      hist_mem[haddr_r] <= '0;
    end else if (state_r == ST_HIST_WR) begin
      hist_mem[haddr_r] <= (hdata_r == BIN_SAT) ? hdata_r : hdata_r + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        min_r[i] <= '0;
        max_r[i] <= '0;
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
      frames_r <= '0;
      haddr_r  <= '0;
      s_r      <= '0;
    end else begin
      case (state_r)
        ST_CLEAR:    haddr_r <= haddr_r + HA'(1);
        ST_IDLE:     s_r <= '0;
        ST_FOLD: begin
          if ((cnt_r[sidx] == 32'd0) || (t_cur < min_r[sidx])) min_r[sidx] <= t_cur;
          if (t_cur > max_r[sidx]) max_r[sidx] <= t_cur;
          sum_r[sidx] <= sum_r[sidx] + {32'd0, t_cur};
          cnt_r[sidx] <= cnt_r[sidx] + 32'd1;
        end
        ST_BIN_WAIT: if (div_done) haddr_r <= row_base + HA'(bin_clamp);
        ST_HIST_WR:  s_r <= s_r + CW'(1);
        ST_FRAME: begin
          frames_r <= frames_r + 32'd1;
          s_r      <= '0;
        end
        ST_LSEL:     if ((s_r != CW'(STAGES)) && !nz[sidx]) s_r <= s_r + CW'(1);
        ST_MEAN_WAIT: begin
          if (div_done) begin
            mean_r     <= div_quot[31:0];
            pct_prod_r <= 64'(cnt_r[sidx]) * 64'(PCT_RECIP);
          end
        end
        ST_PCT_WAIT: begin
          target_r <= cnt_r[sidx] - {5'd0, pct_prod_r[63:PCT_SHIFT]};
          acc_r    <= '0;
          b_r      <= '0;
          haddr_r  <= row_base;
        end
        ST_SCAN_CHK: begin
          acc_r <= acc_sum;
          if (hit || last_bin) begin
            mult_r <= hit ? BCW'(b_r) + BCW'(1) : BCW'(HIST_BINS);
          end else begin
            b_r     <= b_r + BW'(1);
            haddr_r <= haddr_r + HA'(1);
          end
        end
        ST_P99_MUL:  p99_r <= prod[21:0];
        ST_LPUSH:    if (!res_full) s_r <= s_r + CW'(1);
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/slp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// slp_out_fifo
// Four-entry result queue between the back end and the result port.
// ----------------------------------------------------------------------------
module slp_out_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  slp_pkg::slp_out_t  wdata,
  output logic               full,
  input  logic               pop,
  output slp_pkg::slp_out_t  rdata,
  output logic               empty
);
  import slp_pkg::*;

  slp_out_t   mem_r [4];
  logic [1:0] wr_r, rd_r;
  logic [2:0] cnt_r;
  logic       do_push, do_pop;

  assign full    = (cnt_r == 3'd4);
  assign empty   = (cnt_r == 3'd0);
  assign rdata   = mem_r[rd_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 2'd1;
      if (do_pop)  rd_r <= rd_r + 2'd1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 3'd1;
        2'b01:   cnt_r <= cnt_r - 3'd1;
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/stage_latency_profiler_unit.sv -----
// ----------------------------------------------------------------------------
// stage_latency_profiler_unit
// Per-stage latency profiler with histogram p99 reports.
// ----------------------------------------------------------------------------
// channel   ports                        direction
// input     in_push / in_full / in_data  in  (slp_in_t)
// result    out_pop / out_empty / out_data out (slp_out_t)
// config    cfg_we / cfg_addr / cfg_wdata in
//
// Begin and end requests are taken whenever in_full is low. A commit is folded
// stage by stage, each stage waiting on the 64-step divider that finds the
// histogram bin; a report line adds a division for the mean plus a bin-by-bin
// histogram scan. After reset the histogram is swept clear, with in_full high.
// Two commits queue between front and back; four results queue at the output,
// and the back end holds when that queue is full.
// ----------------------------------------------------------------------------
module stage_latency_profiler_unit #(
  parameter int STAGES    = 10,
  parameter int HIST_BINS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  slp_pkg::slp_in_t  in_data,
  output logic              in_full,
  output logic              out_empty,
  input  logic              out_pop,
  output slp_pkg::slp_out_t out_data,
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [15:0]       cfg_wdata
);
  import slp_pkg::*;

  logic [15:0]             bin_width_r, report_every_r;
  logic                    cmt_valid, cmt_pop, clearing, res_push, res_full;
  logic [STAGES-1:0][31:0] cmt_accum;
  slp_out_t                res_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_width_r    <= BIN_WIDTH_RST;
      report_every_r <= REPORT_EVERY_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BIN_WIDTH:    bin_width_r    <= cfg_wdata;
        CFG_REPORT_EVERY: report_every_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  slp_front #(.STAGES(STAGES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .clearing  (clearing),
    .cmt_valid (cmt_valid),
    .cmt_accum (cmt_accum),
    .cmt_pop   (cmt_pop)
  );

  slp_back #(.STAGES(STAGES), .HIST_BINS(HIST_BINS)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .bin_width    (bin_width_r),
    .report_every (report_every_r),
    .cmt_valid    (cmt_valid),
    .cmt_accum    (cmt_accum),
    .cmt_pop      (cmt_pop),
    .clearing     (clearing),
    .res_push     (res_push),
    .res_data     (res_data),
    .res_full     (res_full)
  );

  slp_out_fifo u_out (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule

// ----- rtl/core/slp_checker.sv -----
// ----------------------------------------------------------------------------
// slp_checker
// Port-level checks of the stage latency profiler, bound to the top level.
// ----------------------------------------------------------------------------
module slp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_full,
  input logic              out_empty,
  input logic              out_pop,
  input slp_pkg::slp_out_t out_data
);
  import slp_pkg::*;

  // requests are held off as the histogram sweep starts after reset
  a_clear_full: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_full) else $error("input taken during clear");

  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> out_empty) else $error("result right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("stalled result changed");

  a_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_data.last) ##1 !out_empty |-> out_data.kind == KIND_HEADER)
    else $error("report does not restart with a header");

  a_line_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_data.kind == KIND_LINE && !out_data.last) ##1 !out_empty
    |-> (out_data.kind == KIND_LINE &&
         out_data.stage_index > $past(out_data.stage_index)))
    else $error("stage lines out of order");

endmodule

bind stage_latency_profiler_unit slp_checker u_slp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
